### src/rab_pkg.sv
// Shared types, constants and register codes for the rotated bounding box block.
package rab_pkg;

   // Widths fixed by the register map.
   localparam int TRIG_WIDTH      = 16;
   localparam int AXIS_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int NUM_AXES        = 3;
   localparam int AXIS_IDX_WIDTH  = 2;

   // Defaults for the top-level parameters.
   localparam int COORD_WIDTH_DEFAULT    = 32;
   localparam int TRIG_FRAC_BITS_DEFAULT = 14;

   // Register reset values.
   localparam logic [TRIG_WIDTH-1:0] SINE_RESET   = 16'sd0;
   localparam logic [TRIG_WIDTH-1:0] COSINE_RESET = 16'sd16384;

   // Rotation axis codes. Code three is decoded as the z axis.
   typedef enum logic [AXIS_WIDTH-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_code_type;

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROTATION_AXIS = 2'd0,
      REG_SINE_VALUE    = 2'd1,
      REG_COSINE_VALUE  = 2'd2
   } reg_index_type;

   // Rotation set-up as held in the configuration registers.
   typedef struct packed {
      logic [AXIS_WIDTH-1:0]        axis;
      logic signed [TRIG_WIDTH-1:0] sine;
      logic signed [TRIG_WIDTH-1:0] cosine;
   } trig_cfg_type;

   // Positions of the rotation axis and the two plane coordinates.
   typedef struct packed {
      logic [AXIS_IDX_WIDTH-1:0] ax;
      logic [AXIS_IDX_WIDTH-1:0] pb;
      logic [AXIS_IDX_WIDTH-1:0] pc;
   } plane_idx_type;

endpackage

### src/rab_csr.sv
// Configuration registers: rotation axis, sine and cosine.
module rab_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [rab_pkg::CSR_INDEX_WIDTH-1:0]  wr_index,
   input  logic [rab_pkg::CSR_DATA_WIDTH-1:0]   wr_data,
   output rab_pkg::trig_cfg_type                cfg
);
   import rab_pkg::*;

   logic [AXIS_WIDTH-1:0] axis_ff;
   logic [TRIG_WIDTH-1:0] sine_ff;
   logic [TRIG_WIDTH-1:0] cosine_ff;

   // Register writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= AXIS_X;
         sine_ff   <= SINE_RESET;
         cosine_ff <= COSINE_RESET;
      end else if (wr_en) begin
         unique case (wr_index)
            REG_ROTATION_AXIS: axis_ff   <= wr_data[AXIS_WIDTH-1:0];
            REG_SINE_VALUE:    sine_ff   <= wr_data[TRIG_WIDTH-1:0];
            REG_COSINE_VALUE:  cosine_ff <= wr_data[TRIG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.axis   = axis_ff;
   assign cfg.sine   = $signed(sine_ff);
   assign cfg.cosine = $signed(cosine_ff);

endmodule

### src/rab_mult.sv
// Input register, plane selection and the eight corner products, registered.
module rab_mult #(
   parameter  int COORD_WIDTH = rab_pkg::COORD_WIDTH_DEFAULT,
   localparam int PROD_WIDTH  = COORD_WIDTH + rab_pkg::TRIG_WIDTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  rab_pkg::trig_cfg_type                         cfg,
   // Upstream beat.
   input  logic                                          up_valid,
   output logic                                          up_ready,
   input  logic [rab_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] up_lo,
   input  logic [rab_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] up_hi,
   input  logic                                          up_flag,
   // Downstream beat: products for the low and high corner values.
   output logic                                          dn_valid,
   input  logic                                          dn_ready,
   output logic [1:0][PROD_WIDTH-1:0]                    dn_cb,
   output logic [1:0][PROD_WIDTH-1:0]                    dn_sc,
   output logic [1:0][PROD_WIDTH-1:0]                    dn_sb,
   output logic [1:0][PROD_WIDTH-1:0]                    dn_cc,
   output logic [COORD_WIDTH-1:0]                        dn_axis_lo,
   output logic [COORD_WIDTH-1:0]                        dn_axis_hi,
   output rab_pkg::plane_idx_type                        dn_idx,
   output logic                                          dn_flag
);
   import rab_pkg::*;

   logic                                  in_valid_ff;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  lo_ff;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  hi_ff;
   logic                                  flag_ff;
   logic                                  in_ready;

   logic                                  prod_valid_ff;
   logic                                  prod_ready;
   logic [1:0][PROD_WIDTH-1:0]            cb_in, sc_in, sb_in, cc_in;
   logic [1:0][PROD_WIDTH-1:0]            cb_ff, sc_ff, sb_ff, cc_ff;
   logic [COORD_WIDTH-1:0]                axis_lo_ff, axis_hi_ff;
   plane_idx_type                         idx_in, idx_ff;
   logic                                  flag_out_ff;

   logic signed [COORD_WIDTH-1:0]         pb_lo, pb_hi, pc_lo, pc_hi;

   assign prod_ready = !prod_valid_ff || dn_ready;
   assign in_ready   = !in_valid_ff || prod_ready;
   assign up_ready   = in_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && in_ready) begin
         lo_ff   <= up_lo;
         hi_ff   <= up_hi;
         flag_ff <= up_flag;
      end
   end

   // Axis decode: the rotation axis and the two coordinates of its plane.
   always_comb begin
      unique case (cfg.axis)
         AXIS_X: begin
            idx_in.ax = 2'd0;
            idx_in.pb = 2'd1;
            idx_in.pc = 2'd2;
         end
         AXIS_Y: begin
            idx_in.ax = 2'd1;
            idx_in.pb = 2'd0;
            idx_in.pc = 2'd2;
         end
         default: begin
            idx_in.ax = 2'd2;
            idx_in.pb = 2'd0;
            idx_in.pc = 2'd1;
         end
      endcase
   end

   assign pb_lo = $signed(lo_ff[idx_in.pb]);
   assign pb_hi = $signed(hi_ff[idx_in.pb]);
   assign pc_lo = $signed(lo_ff[idx_in.pc]);
   assign pc_hi = $signed(hi_ff[idx_in.pc]);

   // Corner products; index 0 uses the low value, index 1 the high value.
   always_comb begin
      cb_in[0] = pb_lo * cfg.cosine;
      cb_in[1] = pb_hi * cfg.cosine;
      sc_in[0] = pc_lo * cfg.sine;
      sc_in[1] = pc_hi * cfg.sine;
      sb_in[0] = pb_lo * cfg.sine;
      sb_in[1] = pb_hi * cfg.sine;
      cc_in[0] = pc_lo * cfg.cosine;
      cc_in[1] = pc_hi * cfg.cosine;
   end

   // Product register.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         prod_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && prod_ready) begin
         cb_ff       <= cb_in;
         sc_ff       <= sc_in;
         sb_ff       <= sb_in;
         cc_ff       <= cc_in;
         axis_lo_ff  <= lo_ff[idx_in.ax];
         axis_hi_ff  <= hi_ff[idx_in.ax];
         idx_ff      <= idx_in;
         flag_out_ff <= flag_ff;
      end
   end

   assign dn_valid   = prod_valid_ff;
   assign dn_cb      = cb_ff;
   assign dn_sc      = sc_ff;
   assign dn_sb      = sb_ff;
   assign dn_cc      = cc_ff;
   assign dn_axis_lo = axis_lo_ff;
   assign dn_axis_hi = axis_hi_ff;
   assign dn_idx     = idx_ff;
   assign dn_flag    = flag_out_ff;

endmodule

### src/rab_reduce.sv
// Bound reduction: extreme sums, shift, saturation and the result register.
module rab_reduce #(
   parameter  int COORD_WIDTH    = rab_pkg::COORD_WIDTH_DEFAULT,
   parameter  int TRIG_FRAC_BITS = rab_pkg::TRIG_FRAC_BITS_DEFAULT,
   localparam int PROD_WIDTH     = COORD_WIDTH + rab_pkg::TRIG_WIDTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // Upstream beat from the product register.
   input  logic                                          up_valid,
   output logic                                          up_ready,
   input  logic [1:0][PROD_WIDTH-1:0]                    up_cb,
   input  logic [1:0][PROD_WIDTH-1:0]                    up_sc,
   input  logic [1:0][PROD_WIDTH-1:0]                    up_sb,
   input  logic [1:0][PROD_WIDTH-1:0]                    up_cc,
   input  logic [COORD_WIDTH-1:0]                        up_axis_lo,
   input  logic [COORD_WIDTH-1:0]                        up_axis_hi,
   input  rab_pkg::plane_idx_type                        up_idx,
   input  logic                                          up_flag,
   // Result beat.
   output logic                                          dn_valid,
   input  logic                                          dn_ready,
   output logic [rab_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] dn_min,
   output logic [rab_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] dn_max,
   output logic                                          dn_flag
);
   import rab_pkg::*;

   localparam int SUM_WIDTH = PROD_WIDTH + 1;

   logic                                  out_valid_ff;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  min_in, max_in, min_ff, max_ff;
   logic                                  flag_ff;

   logic signed [PROD_WIDTH-1:0]          cb_min, cb_max, sc_min, sc_max;
   logic signed [PROD_WIDTH-1:0]          sb_min, sb_max, cc_min, cc_max;
   logic signed [SUM_WIDTH-1:0]           f_min_sum, f_max_sum, g_min_sum, g_max_sum;
   logic [COORD_WIDTH-1:0]                f_min, f_max, g_min, g_max;
   logic [COORD_WIDTH-1:0]                a_min, a_max;

   // Flooring shift by the fraction width, then saturation to a coordinate.
   function automatic logic [COORD_WIDTH-1:0] shift_sat(input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0]   sh;
      logic [SUM_WIDTH-COORD_WIDTH:0] top;
      sh  = v >>> TRIG_FRAC_BITS;
      top = sh[SUM_WIDTH-1:COORD_WIDTH-1];
      priority if (&top || ~|top) begin
         return sh[COORD_WIDTH-1:0];
      end else if (sh[SUM_WIDTH-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   assign up_ready = !out_valid_ff || dn_ready;

   // Each rotated coordinate is a sum of two independent terms, so its extreme
   // over the four plane corners is the sum of the extremes of the terms.
   always_comb begin
      cb_min = ($signed(up_cb[0]) < $signed(up_cb[1])) ? $signed(up_cb[0]) : $signed(up_cb[1]);
      cb_max = ($signed(up_cb[0]) < $signed(up_cb[1])) ? $signed(up_cb[1]) : $signed(up_cb[0]);
      sc_min = ($signed(up_sc[0]) < $signed(up_sc[1])) ? $signed(up_sc[0]) : $signed(up_sc[1]);
      sc_max = ($signed(up_sc[0]) < $signed(up_sc[1])) ? $signed(up_sc[1]) : $signed(up_sc[0]);
      sb_min = ($signed(up_sb[0]) < $signed(up_sb[1])) ? $signed(up_sb[0]) : $signed(up_sb[1]);
      sb_max = ($signed(up_sb[0]) < $signed(up_sb[1])) ? $signed(up_sb[1]) : $signed(up_sb[0]);
      cc_min = ($signed(up_cc[0]) < $signed(up_cc[1])) ? $signed(up_cc[0]) : $signed(up_cc[1]);
      cc_max = ($signed(up_cc[0]) < $signed(up_cc[1])) ? $signed(up_cc[1]) : $signed(up_cc[0]);
   end

   // First coordinate is cos*first + sin*second, second is cos*second - sin*first.
   assign f_min_sum = cb_min + sc_min;
   assign f_max_sum = cb_max + sc_max;
   assign g_min_sum = cc_min - sb_max;
   assign g_max_sum = cc_max - sb_min;

   // Shift and saturation are monotonic, so they follow the extremes.
   assign f_min = shift_sat(f_min_sum);
   assign f_max = shift_sat(f_max_sum);
   assign g_min = shift_sat(g_min_sum);
   assign g_max = shift_sat(g_max_sum);

   // The axis coordinate is unchanged; an inverted box still gives min <= max.
   assign a_min = ($signed(up_axis_lo) < $signed(up_axis_hi)) ? up_axis_lo : up_axis_hi;
   assign a_max = ($signed(up_axis_lo) < $signed(up_axis_hi)) ? up_axis_hi : up_axis_lo;

   // Route the bounds back to their axes.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         priority if (AXIS_IDX_WIDTH'(k) == up_idx.ax) begin
            min_in[k] = a_min;
            max_in[k] = a_max;
         end else if (AXIS_IDX_WIDTH'(k) == up_idx.pb) begin
            min_in[k] = f_min;
            max_in[k] = f_max;
         end else begin
            min_in[k] = g_min;
            max_in[k] = g_max;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (up_ready) begin
         out_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         flag_ff <= up_flag;
      end
   end

   assign dn_valid = out_valid_ff;
   assign dn_min   = min_ff;
   assign dn_max   = max_ff;
   assign dn_flag  = flag_ff;

endmodule

### src/rotated_aabb_bound.sv
// Top level of the rotated bounding box block: ports, packing and checks.
//
// Takes one axis-aligned box per beat and returns the axis-aligned bound of
// that box rotated about the configured axis by the configured fixed-point
// sine and cosine, with the valid flag copied through. One box is accepted in
// every cycle while the output is not held back. The input register takes
// the box, the corner multipliers fill the product register and the bound
// reduction fills the result register, which offers the bound. All three
// stages hold their contents under back-pressure, so up to three boxes are
// in flight. Rotated coordinates are floored by the fraction width of the
// trigonometric values and saturate to the coordinate width. Configuration
// writes are taken at any time but must only be issued while no box is in
// flight.
module rotated_aabb_bound #(
   parameter  int COORD_WIDTH    = rab_pkg::COORD_WIDTH_DEFAULT,
   parameter  int TRIG_FRAC_BITS = rab_pkg::TRIG_FRAC_BITS_DEFAULT,
   localparam int TDATA_WIDTH    = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input boxes.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: in_min_x, in_min_y, in_min_z, in_max_x, in_max_y,
   // in_max_z, zero padding.
   input  logic [TDATA_WIDTH-1:0]               req_tdata,
   // Fields from bit 0: in_box_valid.
   input  logic                                 req_tuser,
   // Rotated bounds.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
   // out_max_z, zero padding.
   output logic [TDATA_WIDTH-1:0]               rsp_tdata,
   // Fields from bit 0: out_box_valid.
   output logic                                 rsp_tuser,
   // Configuration writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rab_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rab_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import rab_pkg::*;

   localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;

   trig_cfg_type                          cfg;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  box_lo, box_hi;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  bound_min, bound_max;

   logic                                  prod_valid, prod_ready;
   logic [1:0][PROD_WIDTH-1:0]            prod_cb, prod_sc, prod_sb, prod_cc;
   logic [COORD_WIDTH-1:0]                prod_axis_lo, prod_axis_hi;
   plane_idx_type                         prod_idx;
   logic                                  prod_flag;

   assign csr_ready = 1'b1;

   rab_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Unpack the input beat.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         box_lo[k] = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
         box_hi[k] = req_tdata[(k+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   rab_mult #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .up_lo      (box_lo),
      .up_hi      (box_hi),
      .up_flag    (req_tuser),
      .dn_valid   (prod_valid),
      .dn_ready   (prod_ready),
      .dn_cb      (prod_cb),
      .dn_sc      (prod_sc),
      .dn_sb      (prod_sb),
      .dn_cc      (prod_cc),
      .dn_axis_lo (prod_axis_lo),
      .dn_axis_hi (prod_axis_hi),
      .dn_idx     (prod_idx),
      .dn_flag    (prod_flag)
   );

   rab_reduce #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (prod_valid),
      .up_ready   (prod_ready),
      .up_cb      (prod_cb),
      .up_sc      (prod_sc),
      .up_sb      (prod_sb),
      .up_cc      (prod_cc),
      .up_axis_lo (prod_axis_lo),
      .up_axis_hi (prod_axis_hi),
      .up_idx     (prod_idx),
      .up_flag    (prod_flag),
      .dn_valid   (rsp_tvalid),
      .dn_ready   (rsp_tready),
      .dn_min     (bound_min),
      .dn_max     (bound_max),
      .dn_flag    (rsp_tuser)
   );

   // Pack the result beat; padding bits read as zero.
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         rsp_tdata[k*COORD_WIDTH +: COORD_WIDTH]            = bound_min[k];
         rsp_tdata[(k+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH] = bound_max[k];
      end
   end

   // No result is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // The input side only stalls when all three stages are full and the output waits.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the pipeline had room");

   // Every offered bound has its minimum at or below its maximum on each axis.
   a_bound_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[0*COORD_WIDTH +: COORD_WIDTH]) <=
          $signed(rsp_tdata[3*COORD_WIDTH +: COORD_WIDTH])) &&
         ($signed(rsp_tdata[1*COORD_WIDTH +: COORD_WIDTH]) <=
          $signed(rsp_tdata[4*COORD_WIDTH +: COORD_WIDTH])) &&
         ($signed(rsp_tdata[2*COORD_WIDTH +: COORD_WIDTH]) <=
          $signed(rsp_tdata[5*COORD_WIDTH +: COORD_WIDTH])))
      else $error("result minimum above maximum");

endmodule

### test/tb.sv
// Self-checking testbench for the rotated bounding box block.
`timescale 1ns / 1ps

module tb;
   import rab_pkg::*;

   localparam int COORD_W        = COORD_WIDTH_DEFAULT;
   localparam int TRIG_FRAC      = TRIG_FRAC_BITS_DEFAULT;
   localparam int TDATA_W        = ((6 * COORD_W + 7) / 8) * 8;
   localparam int PIPE_SETTLE    = 6;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_BOXES    = 50;

   // Codes outside the decoded sets, both still legal on the ports.
   localparam logic [AXIS_WIDTH-1:0]      AXIS_CODE_THREE = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED      = 2'd3;

   localparam longint COORD_HI = 64'sd2147483647;
   localparam longint COORD_LO = -64'sd2147483648;

   // One box or one bound: six coordinates from bit 0 up, plus the valid flag.
   typedef struct packed {
      logic [5:0][COORD_W-1:0] coord;
      logic                    valid;
   } box_beat_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   // Fields from bit 0: in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z.
   logic [TDATA_W-1:0]         req_tdata;
   // Fields from bit 0: in_box_valid.
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   // Fields from bit 0: out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
   // out_max_z.
   logic [TDATA_W-1:0]         rsp_tdata;
   // Fields from bit 0: out_box_valid.
   logic                       rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   // Boxes waiting to be sent and bounds waiting to come back.
   box_beat_type box_pending [$];
   box_beat_type bound_queue [$];

   // Copy of the rotation set-up as the block should hold it.
   logic [AXIS_WIDTH-1:0]        rot_axis;
   logic signed [TRIG_WIDTH-1:0] sine_reg;
   logic signed [TRIG_WIDTH-1:0] cosine_reg;

   logic         req_fire;
   int           req_gap;
   int           rsp_stall;
   bit           calm;
   int           idle_cycles;
   int           mismatch_count;
   box_beat_type tx_beat;
   box_beat_type got_bound;
   box_beat_type want_bound;
   int           fk;

   rotated_aabb_bound DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Floor by the fraction width, then clamp to the coordinate range.
   function automatic longint floor_sat(input longint acc);
      longint q;
      q = acc >>> TRIG_FRAC;
      if (q > COORD_HI) return COORD_HI;
      if (q < COORD_LO) return COORD_LO;
      return q;
   endfunction

   // Bound of the box after rotating all eight corners with the held set-up.
   function automatic box_beat_type rotated_bound(input box_beat_type b);
      longint       lo3 [3];
      longint       hi3 [3];
      longint       pt [3];
      longint       rt [3];
      longint       bmin [3];
      longint       bmax [3];
      longint       s;
      longint       c;
      int           ax;
      int           pb;
      int           pc;
      box_beat_type r;
      s = longint'(sine_reg);
      c = longint'(cosine_reg);
      case (rot_axis)
         AXIS_X: begin
            ax = 0; pb = 1; pc = 2;
         end
         AXIS_Y: begin
            ax = 1; pb = 0; pc = 2;
         end
         default: begin
            ax = 2; pb = 0; pc = 1;
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         lo3[k] = longint'($signed(b.coord[k]));
         hi3[k] = longint'($signed(b.coord[k + 3]));
      end
      for (int corner = 0; corner < 8; corner++) begin
         for (int k = 0; k < 3; k++)
            pt[k] = corner[k] ? hi3[k] : lo3[k];
         rt[ax] = pt[ax];
         rt[pb] = floor_sat(c * pt[pb] + s * pt[pc]);
         rt[pc] = floor_sat(-s * pt[pb] + c * pt[pc]);
         for (int k = 0; k < 3; k++) begin
            if (corner == 0 || rt[k] < bmin[k]) bmin[k] = rt[k];
            if (corner == 0 || rt[k] > bmax[k]) bmax[k] = rt[k];
         end
      end
      for (int k = 0; k < 3; k++) begin
         r.coord[k]     = bmin[k][COORD_W-1:0];
         r.coord[k + 3] = bmax[k][COORD_W-1:0];
      end
      r.valid = b.valid;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic box_beat_type make_box(input logic [COORD_W-1:0] x0, y0, z0, x1, y1, z1,
                                             input logic v);
      box_beat_type b;
      b.coord = {z1, y1, x1, z0, y0, x0};
      b.valid = v;
      return b;
   endfunction

   // Small values near the origin, full-width patterns and the extremes.
   function automatic logic [COORD_W-1:0] rand_coord();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         v = int'($urandom_range(0, 2097152)) - 1048576;
         return COORD_W'(v);
      end
      if (r < 7) return COORD_W'($urandom);
      if (r == 7) return 32'h7fffffff - $urandom_range(0, 2);
      if (r == 8) return 32'h80000000 + $urandom_range(0, 2);
      return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
   endfunction

   // Well-formed boxes most of the time, inverted ones and pure noise otherwise.
   function automatic box_beat_type rand_box();
      box_beat_type            b;
      logic [COORD_W-1:0]      a;
      logic [COORD_W-1:0]      z;
      if ($urandom_range(0, 9) == 0) begin
         for (int k = 0; k < 6; k++) b.coord[k] = COORD_W'($urandom);
      end else begin
         for (int k = 0; k < 3; k++) begin
            a = rand_coord();
            z = rand_coord();
            if ($urandom_range(0, 9) < 8 && $signed(a) > $signed(z)) begin
               b.coord[k]     = z;
               b.coord[k + 3] = a;
            end else begin
               b.coord[k]     = a;
               b.coord[k + 3] = z;
            end
         end
      end
      b.valid = ($urandom_range(0, 4) != 0);
      return b;
   endfunction

   function automatic logic [TRIG_WIDTH-1:0] rand_trig();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return TRIG_WIDTH'(int'($urandom_range(0, 32768)) - 16384);
      if (r == 6) return 16'sd16384;
      if (r == 7) return -16'sd16384;
      if (r == 8) return 16'd0;
      return TRIG_WIDTH'($urandom);
   endfunction

   // One write beat on the configuration channel.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_setting(input logic [AXIS_WIDTH-1:0] axis,
                                input logic [TRIG_WIDTH-1:0] sine,
                                input logic [TRIG_WIDTH-1:0] cosine);
      write_reg(REG_ROTATION_AXIS,
                {(CSR_DATA_WIDTH-AXIS_WIDTH)'($urandom_range(0, 16383)), axis});
      write_reg(REG_SINE_VALUE, sine);
      write_reg(REG_COSINE_VALUE, cosine);
   endtask

   // Wait until every box has been sent and every bound has come back.
   task automatic drain_pipeline();
      while (box_pending.size() != 0 || req_tvalid) @(posedge clock);
      @(negedge clock);
      while (bound_queue.size() != 0) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   // Extremes, an inverted invalid box and a box of ordinary values.
   task automatic push_directed();
      box_pending.push_back(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
      box_pending.push_back(make_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                     32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
      box_pending.push_back(make_box(32'h00010000, 32'hfffd8000, 32'h00030000,
                                     32'h00040000, 32'h00008000, 32'h00070000, 1'b1));
   endtask

   // Box driver: a new beat after the last one went, or after a gap.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (box_pending.size() > 0) begin
            tx_beat = box_pending.pop_front();
            req_tdata  <= tx_beat.coord;
            req_tuser  <= tx_beat.valid;
            req_tvalid <= 1'b1;
            req_gap    <= calm ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result back-pressure.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall  <= calm ? 0 : pick_gap();
      end
   end

   // Monitor: track the set-up, predict each accepted box, check each bound.
   always @(posedge clock) begin
      if (reset) begin
         rot_axis    = AXIS_X;
         sine_reg    = SINE_RESET;
         cosine_reg  = COSINE_RESET;
         req_fire    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_ROTATION_AXIS: rot_axis   = csr_data[AXIS_WIDTH-1:0];
               REG_SINE_VALUE:    sine_reg   = csr_data;
               REG_COSINE_VALUE:  cosine_reg = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            tx_beat.coord = req_tdata[6*COORD_W-1:0];
            tx_beat.valid = req_tuser;
            bound_queue.push_back(rotated_bound(tx_beat));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_bound.coord = rsp_tdata[6*COORD_W-1:0];
            got_bound.valid = rsp_tuser;
            if (bound_queue.size() == 0) begin
               report_mismatch($sformatf("bound %h arrived with no box outstanding",
                                         got_bound));
            end else begin
               want_bound = bound_queue.pop_front();
               for (fk = 0; fk < 6; fk++) begin
                  if (got_bound.coord[fk] !== want_bound.coord[fk])
                     report_mismatch($sformatf("field %0d got %h expected %h", fk,
                                               got_bound.coord[fk], want_bound.coord[fk]));
               end
               if (got_bound.valid !== want_bound.valid)
                  report_mismatch($sformatf("valid flag got %b expected %b",
                                            got_bound.valid, want_bound.valid));
            end
         end
         req_fire    <= req_tvalid && req_tready;
         idle_cycles <= (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                        (csr_valid && csr_ready) ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog on cycles without any accepted beat.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = REG_ROTATION_AXIS;
      csr_data       = '0;
      req_gap        = 0;
      rsp_stall      = 0;
      calm           = 1'b0;
      mismatch_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset set-up: identity rotation about x.
      @(posedge clock);
      box_pending.push_back(make_box('0, '0, '0, '0, '0, '0, 1'b1));
      push_directed();
      drain_pipeline();

      // Directed set-ups: quarter, eighth and half turns, code three, out-of-range trig.
      write_setting(AXIS_X, 16'sd16384, 16'sd0);
      @(posedge clock);
      push_directed();
      drain_pipeline();
      write_setting(AXIS_Y, 16'sd11585, 16'sd11585);
      @(posedge clock);
      push_directed();
      drain_pipeline();
      write_setting(AXIS_Z, -16'sd16384, -16'sd16384);
      @(posedge clock);
      push_directed();
      drain_pipeline();
      write_setting(AXIS_CODE_THREE, 16'sd0, -16'sd16384);
      // A write to the unused index must leave the set-up alone.
      write_reg(REG_UNUSED, 16'hffff);
      @(posedge clock);
      push_directed();
      drain_pipeline();
      write_setting(AXIS_Z, 16'h8000, 16'h7fff);
      @(posedge clock);
      push_directed();
      drain_pipeline();
      write_setting(AXIS_Y, 16'h7fff, 16'h8000);
      @(posedge clock);
      push_directed();
      drain_pipeline();

      // Random set-ups, each followed by a run of random boxes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_setting(AXIS_WIDTH'($urandom_range(0, 3)), rand_trig(), rand_trig());
         if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CSR_DATA_WIDTH'($urandom));
         @(posedge clock);
         calm = (ph % 4 == 3);
         for (int n = 0; n < PHASE_BOXES; n++) box_pending.push_back(rand_box());
         drain_pipeline();
      end

      if (bound_queue.size() != 0)
         report_mismatch($sformatf("%0d bounds never arrived", bound_queue.size()));
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
src/rab_pkg.sv
src/rab_csr.sv
src/rab_mult.sv
src/rab_reduce.sv
src/rotated_aabb_bound.sv
test/tb.sv
